// File: hw/rtl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the parser front end, the frame queue and
// the delivery back end.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned LEFT_W   = 4;

    localparam logic [6:0]          LEN_EXT16     = 7'd126;
    localparam logic [6:0]          LEN_EXT64     = 7'd127;
    localparam logic [LEFT_W-1:0]   EXT16_BYTES   = 4'd2;
    localparam logic [LEFT_W-1:0]   EXT64_BYTES   = 4'd8;
    localparam logic [OPCODE_W-1:0] OPCODE_RESET  = 4'h2;

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_HDR0    = 4'b0001,
        PH_HDR1    = 4'b0010,
        PH_EXTLEN  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } wsdf_phase_t;

    // One classified item as handed from the front end to the back end.
    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                is_payload;
        logic                last;
        logic [OPCODE_W-1:0] opcode;
    } wsdf_item_t;

    // Queue status seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } wsdf_qstat_t;

endpackage

// File: hw/rtl/wsdf_front.sv
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses the header of each frame and classifies every received byte; emits
// payload items and empty-frame end markers toward the frame queue.
// ----------------------------------------------------------------------------
module wsdf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [wsdf_pkg::BYTE_W-1:0] rx_byte,
    output logic                        item_push,
    output wsdf_pkg::wsdf_item_t        item
);
    import wsdf_pkg::*;

    wsdf_phase_t         phase_reg, phase_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]    remain_reg, remain_next;

    logic [6:0]          len7;
    logic [LEN_W-1:0]    shifted;
    logic [LEFT_W-1:0]   left_dec;
    logic [LEN_W-1:0]    remain_dec;

    assign len7       = rx_byte[6:0];
    assign shifted    = {remain_reg[LEN_W-BYTE_W-1:0], rx_byte};
    assign left_dec   = (left_reg != '0) ? left_reg - 1'b1 : '0;
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : '0;

    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        left_next       = left_reg;
        remain_next     = remain_reg;
        item_push       = 1'b0;
        item.data       = '0;
        item.is_payload = 1'b0;
        item.last       = 1'b1;
        item.opcode     = opcode_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[OPCODE_W-1:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (len7 == LEN_EXT16)
                    begin
                        left_next   = EXT16_BYTES;
                        remain_next = '0;
                        phase_next  = PH_EXTLEN;
                    end
                    else if (len7 == LEN_EXT64)
                    begin
                        left_next   = EXT64_BYTES;
                        remain_next = '0;
                        phase_next  = PH_EXTLEN;
                    end
                    else
                    begin
                        left_next   = '0;
                        remain_next = {{(LEN_W-7){1'b0}}, len7};
                        if (len7 == '0)
                        begin
                            // An empty frame ends on its length byte.
                            item_push  = 1'b1;
                            phase_next = PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    remain_next = shifted;
                    left_next   = left_dec;
                    if (left_dec == '0)
                    begin
                        if (shifted == '0)
                        begin
                            item_push  = 1'b1;
                            phase_next = PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next     = remain_dec;
                    item_push       = 1'b1;
                    item.data       = rx_byte;
                    item.is_payload = 1'b1;
                    item.last       = (remain_dec == '0);
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            left_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            left_reg   <= left_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// File: hw/rtl/wsdf_queue.sv
// ----------------------------------------------------------------------------
// WebSocket deframer item queue
// Small first-in first-out buffer of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module wsdf_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  wsdf_pkg::wsdf_item_t wr_item,
    input  logic                 rd_en,
    output wsdf_pkg::wsdf_item_t rd_item,
    output wsdf_pkg::wsdf_qstat_t stat
);
    import wsdf_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsdf_item_t      mem [DEPTH];
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en & ~stat.full;
    assign do_rd      = rd_en & ~stat.empty;
    assign rd_item    = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/wsdf_back.sv
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Filters queued items against the accepted opcode, drops the others and
// holds the delivered result in an output register.
// ----------------------------------------------------------------------------
module wsdf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsdf_pkg::OPCODE_W-1:0] accept_opcode,
    input  wsdf_pkg::wsdf_qstat_t         qstat,
    input  wsdf_pkg::wsdf_item_t          q_item,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [wsdf_pkg::BYTE_W-1:0]   data_byte,
    output logic                          byte_valid,
    output logic                          frame_end,
    output logic [wsdf_pkg::OPCODE_W-1:0] frame_opcode
);
    import wsdf_pkg::*;

    logic [OPCODE_W-1:0] accept_reg;
    logic                out_valid_reg, out_valid_next;
    wsdf_item_t          out_reg;
    logic                keep, slot_free, load;

    assign cfg_ready = 1'b1;

    // Items of other opcodes leave the queue without reaching the output.
    assign keep      = (q_item.opcode == accept_reg);
    assign slot_free = ~out_valid_reg | pop;
    assign q_pop     = ~qstat.empty & (~keep | slot_free);
    assign load      = ~qstat.empty & keep & slot_free;

    assign out_valid_next = load | (out_valid_reg & ~pop);

    assign empty        = ~out_valid_reg;
    assign data_byte    = out_reg.data;
    assign byte_valid   = out_reg.is_payload;
    assign frame_end    = out_reg.last;
    assign frame_opcode = out_reg.opcode;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_reg    <= OPCODE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                accept_reg <= accept_opcode;
            end
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Splits a received byte stream into WebSocket frames and delivers the
// payload of frames carrying the configured opcode.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while full is low and
// delivers one result per cycle while pop is held and results wait. A
// header parser classifies every byte in the cycle it arrives; its critical
// path is the 64-bit payload counter decrement and zero test. Payload bytes
// and empty-frame end markers pass through a queue of QUEUE_DEPTH items to
// an output register, so the input keeps flowing while a result waits to be
// popped, and full rises only when the queue is full. A result whose byte
// finds nothing ahead of it is written into the queue and then loaded into
// the output register, from which it can be popped. Bytes of frames whose
// opcode differs from accept_opcode are discarded at the queue head at one
// per cycle; write accept_opcode only while the block is idle.
module websocket_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [wsdf_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsdf_pkg::OPCODE_W-1:0] accept_opcode,
    output logic                          empty,
    input  logic                          pop,
    output logic [wsdf_pkg::BYTE_W-1:0]   data_byte,
    output logic                          byte_valid,
    output logic                          frame_end,
    output logic [wsdf_pkg::OPCODE_W-1:0] frame_opcode
);
    import wsdf_pkg::*;

    wsdf_qstat_t qstat;
    wsdf_item_t  front_item;
    wsdf_item_t  head_item;
    logic        front_push;
    logic        q_pop;
    logic        take;

    assign full = qstat.full;
    assign take = push & ~qstat.full;

    wsdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .item_push (front_push),
        .item      (front_item)
    );

    wsdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_item (front_item),
        .rd_en   (q_pop),
        .rd_item (head_item),
        .stat    (qstat)
    );

    wsdf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .accept_opcode (accept_opcode),
        .qstat         (qstat),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .frame_end     (frame_end),
        .frame_opcode  (frame_opcode)
    );

endmodule

// File: bench/websocket_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer checker
// Follows the byte stream into the deframer, works out which payload bytes
// and empty-frame markers must come out, and compares every popped item.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [wsdf_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [wsdf_pkg::OPCODE_W-1:0] accept_opcode,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [wsdf_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          byte_valid,
    input  logic                          frame_end,
    input  logic [wsdf_pkg::OPCODE_W-1:0] frame_opcode,
    output int                            mismatch_count,
    output int                            results_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    // Parser state as the stream has left it.
    wsdf_phase_t         parse_phase;
    logic [OPCODE_W-1:0] frame_op;
    logic [LEFT_W-1:0]   ext_len_left;
    logic [LEN_W-1:0]    bytes_due;
    logic [OPCODE_W-1:0] wanted_op;

    wsdf_item_t owed_items[$];
    wsdf_item_t want;
    wsdf_item_t made;
    int         fails;

    // The length field is complete: an empty frame ends here, otherwise the
    // payload follows.
    function automatic bit close_length(output wsdf_item_t res);
        res = '0;
        if (bytes_due == '0)
        begin
            parse_phase = PH_HDR0;
            if (frame_op != wanted_op)
                return 1'b0;
            res = '{data: '0, is_payload: 1'b0, last: 1'b1, opcode: frame_op};
            return 1'b1;
        end
        parse_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                        output wsdf_item_t res);
        res = '0;
        case (parse_phase)
            PH_HDR0:
            begin
                frame_op    = b[OPCODE_W-1:0];
                parse_phase = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1:
            begin
                bytes_due = '0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64)
                begin
                    ext_len_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    parse_phase  = PH_EXTLEN;
                    return 1'b0;
                end
                ext_len_left = '0;
                bytes_due    = LEN_W'(b[6:0]);
                return close_length(res);
            end
            PH_EXTLEN:
            begin
                bytes_due = {bytes_due[LEN_W-BYTE_W-1:0], b};
                if (ext_len_left != '0)
                    ext_len_left = ext_len_left - 1'b1;
                if (ext_len_left == '0)
                    return close_length(res);
                return 1'b0;
            end
            default:
            begin
                if (bytes_due != '0)
                    bytes_due = bytes_due - 1'b1;
                if (bytes_due == '0)
                    parse_phase = PH_HDR0;
                if (frame_op != wanted_op)
                    return 1'b0;
                res = '{data: b, is_payload: 1'b1, last: (bytes_due == '0),
                        opcode: frame_op};
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase  = PH_HDR0;
            frame_op     = '0;
            ext_len_left = '0;
            bytes_due    = '0;
            wanted_op    = OPCODE_RESET;
            owed_items.delete();
            fails = 0;
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (owed_items.size() == 0)
                begin
                    $error("extra item: data_byte %0h byte_valid %0b frame_end %0b frame_opcode %0h",
                           data_byte, byte_valid, frame_end, frame_opcode);
                    fails++;
                end
                else
                begin
                    want = owed_items.pop_front();
                    if (data_byte !== want.data)
                    begin
                        $error("data_byte: expected %0h, got %0h", want.data, data_byte);
                        fails++;
                    end
                    if (byte_valid !== want.is_payload)
                    begin
                        $error("byte_valid: expected %0b, got %0b", want.is_payload, byte_valid);
                        fails++;
                    end
                    if (frame_end !== want.last)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.last, frame_end);
                        fails++;
                    end
                    if (frame_opcode !== want.opcode)
                    begin
                        $error("frame_opcode: expected %0h, got %0h", want.opcode, frame_opcode);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                wanted_op = accept_opcode;
            if (push && !full)
            begin
                if (deframe_byte(rx_byte, made))
                    owed_items.insert(owed_items.size(), made);
            end
            mismatch_count <= fails;
            results_owed   <= owed_items.size();
        end
    end

endmodule

// File: bench/websocket_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds directed and random frame streams with random gaps on both sides,
// changes the accepted opcode between phases and reports the verdict.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_BYTES     = 270;

    typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [BYTE_W-1:0]   rx_byte;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [OPCODE_W-1:0] accept_opcode;
    logic                empty;
    logic                pop;
    logic [BYTE_W-1:0]   data_byte;
    logic                byte_valid;
    logic                frame_end;
    logic [OPCODE_W-1:0] frame_opcode;
    int                  mismatch_count;
    int                  results_owed;

    logic [BYTE_W-1:0]   frame_buf[$];
    logic [OPCODE_W-1:0] cur_accept;
    int                  sent;
    bit                  send_burst;
    int                  idle_cycles;

    websocket_frame_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .accept_opcode(accept_opcode),
        .empty        (empty),
        .pop          (pop),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .frame_end    (frame_end),
        .frame_opcode (frame_opcode)
    );

    websocket_frame_deframer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .accept_opcode (accept_opcode),
        .empty         (empty),
        .pop           (pop),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .frame_end     (frame_end),
        .frame_opcode  (frame_opcode),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void append_byte(input logic [BYTE_W-1:0] b);
        frame_buf.insert(frame_buf.size(), b);
    endfunction

    // Builds one frame header with random FIN/RSV and mask bits, followed by
    // body random payload bytes.
    function automatic void make_frame(input logic [OPCODE_W-1:0] op,
                                       input logic [LEN_W-1:0] len,
                                       input len_form_t form, input int body);
        frame_buf.delete();
        append_byte({4'($urandom_range(0, 15)), op});
        case (form)
            FORM_SHORT:
                append_byte({1'($urandom_range(0, 1)), len[6:0]});
            FORM_EXT16:
            begin
                append_byte({1'($urandom_range(0, 1)), LEN_EXT16});
                append_byte(len[15:8]);
                append_byte(len[7:0]);
            end
            default:
            begin
                append_byte({1'($urandom_range(0, 1)), LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    append_byte(len[8*i +: 8]);
            end
        endcase
        repeat (body)
            append_byte(8'($urandom));
    endfunction

    // Mostly short lengths so that frames turn over quickly; about half the
    // frames carry the opcode that is currently delivered.
    function automatic void pick_frame();
        logic [OPCODE_W-1:0] op;
        logic [LEN_W-1:0]    len;
        len_form_t           form;
        int                  r;
        op = ($urandom_range(0, 1) == 1) ? cur_accept : 4'($urandom_range(0, 15));
        r  = $urandom_range(0, 19);
        if (r < 12)
        begin
            form = FORM_SHORT;
            len  = LEN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 125)
                                                       : $urandom_range(0, 12));
        end
        else
        begin
            form = (r < 17) ? FORM_EXT16 : FORM_EXT64;
            len  = LEN_W'(($urandom_range(0, 14) == 0) ? $urandom_range(126, 300)
                                                        : $urandom_range(0, 20));
        end
        make_frame(op, len, form, int'(len));
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (sent % 40 == 0)
            send_burst = ($urandom_range(0, 3) == 0);
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            push    <= 1'b0;
            rx_byte <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        rx_byte <= b;
        push    <= 1'b1;
        do @(posedge clk); while (full);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_buf(input int from, input int till);
        for (int i = from; i < till; i++)
            send_byte(frame_buf[i]);
    endtask

    // The register may only change once every owed item is out and any
    // dropped bytes have left the queue.
    task automatic set_accept(input logic [OPCODE_W-1:0] op);
        push <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid     <= 1'b1;
        accept_opcode <= op;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        cur_accept  = op;
    endtask

    initial
    begin : stream_source
        logic [OPCODE_W-1:0] phase_accept[0:5];
        int                  k;
        push          = 1'b0;
        rx_byte       = '0;
        cfg_valid     = 1'b0;
        accept_opcode = OPCODE_RESET;
        rst_n         = 1'b0;
        cur_accept    = OPCODE_RESET;
        sent          = 0;
        send_burst    = 1'b0;
        phase_accept  = '{4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'd9,
                          4'($urandom_range(0, 15)), OPCODE_RESET};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty frame, one-byte frame with the mask bit, a dropped frame with
        // all header bits set, a non-minimal 16-bit length and a 64-bit zero
        // length.
        frame_buf = {8'h82, 8'h00,
                     8'h82, 8'h81, 8'hFF,
                     8'hFF, 8'h01, 8'h00,
                     8'h02, 8'hFE, 8'h00, 8'h03, 8'h00, 8'h80, 8'h7F,
                     8'h82, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00};
        send_buf(0, frame_buf.size());

        // Switch the delivered opcode halfway through a frame's payload.
        frame_buf = {8'h02, 8'h04, 8'h11, 8'h22, 8'h33, 8'h44};
        send_buf(0, 4);
        set_accept(phase_accept[0]);
        send_buf(4, frame_buf.size());

        for (int p = 0; p < 6; p++)
        begin
            k = sent + PHASE_BYTES;
            while (sent < k)
            begin
                pick_frame();
                send_buf(0, frame_buf.size());
            end
            if (p < 5)
            begin
                pick_frame();
                k = $urandom_range(0, frame_buf.size());
                send_buf(0, k);
                set_accept(phase_accept[p + 1]);
                send_buf(k, frame_buf.size());
            end
        end

        // A frame too long to finish closes the stream.
        make_frame(cur_accept, {1'b1, 63'({$urandom, $urandom})}, FORM_EXT64, 24);
        send_buf(0, frame_buf.size());

        push <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("websocket_frame_deframer verification clean");
        else
            $display("websocket_frame_deframer verification failed");
        $finish;
    end

    initial
    begin : result_sink
        int  gap;
        int  taken;
        bit  burst;
        pop   = 1'b0;
        taken = 0;
        burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            // Two long stalls let the queue fill while bytes keep coming.
            if (taken == 150 || taken == 500)
                gap = HOLD_OFF_CYCLES;
            else
                gap = burst ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("websocket_frame_deframer verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: files.f
hw/rtl/wsdf_pkg.sv
hw/rtl/wsdf_front.sv
hw/rtl/wsdf_queue.sv
hw/rtl/wsdf_back.sv
hw/rtl/websocket_frame_deframer.sv
bench/websocket_frame_deframer_checker.sv
bench/websocket_frame_deframer_tb.sv
